FILE: rtl/core/cts_pkg.sv
// Shared types and constants for the C token scanner.
package cts_pkg;

    typedef struct packed {
        logic [7:0] src_byte;
        logic       end_of_file;
    } in_item_t;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [23:0] start_offset;
        logic [23:0] end_offset;
        logic [23:0] line_number;
        logic [23:0] line_start_offset;
        logic [7:0]  char_value;
        logic [2:0]  error_code;
        logic        final_token;
    } out_item_t;

    // tokens caused by one byte, in order
    typedef struct packed {
        logic [1:0]  count;
        out_item_t   tok0;
        out_item_t   tok1;
    } tok_pair_t;

    localparam logic [5:0] K_DOT = 6'd0, K_COMMA = 6'd1, K_SEMI = 6'd2, K_LPAREN = 6'd3,
        K_RPAREN = 6'd4, K_LBRACKET = 6'd5, K_RBRACKET = 6'd6, K_LBRACE = 6'd7,
        K_RBRACE = 6'd8, K_QUES = 6'd9, K_TILDE = 6'd10, K_AMPAMP = 6'd11,
        K_AMPEQ = 6'd12, K_AMP = 6'd13, K_STAREQ = 6'd14, K_STAR = 6'd15,
        K_PLUSPLUS = 6'd16, K_PLUSEQ = 6'd17, K_PLUS = 6'd18, K_SUBSUB = 6'd19,
        K_SUBEQ = 6'd20, K_ARROW = 6'd21, K_SUB = 6'd22, K_BANGEQ = 6'd23,
        K_BANG = 6'd24, K_SLASHEQ = 6'd25, K_SLASH = 6'd26, K_PERCENTEQ = 6'd27,
        K_PERCENT = 6'd28, K_LTLTEQ = 6'd29, K_LTLT = 6'd30, K_LTEQ = 6'd31,
        K_LT = 6'd32, K_GTGTEQ = 6'd33, K_GTGT = 6'd34, K_GTEQ = 6'd35, K_GT = 6'd36,
        K_CARETEQ = 6'd37, K_CARET = 6'd38, K_BARBAR = 6'd39, K_BAREQ = 6'd40,
        K_BAR = 6'd41, K_COLONCOLON = 6'd42, K_COLON = 6'd43, K_EQEQ = 6'd44,
        K_EQ = 6'd45, K_IDENT = 6'd46, K_INT = 6'd47, K_FLOAT = 6'd48,
        K_CHAR = 6'd49, K_STRING = 6'd50, K_EOF = 6'd51, K_NONE = 6'd63;

    localparam logic [2:0] E_NONE = 3'd0, E_UNKNOWN = 3'd1, E_EMPTY = 3'd2,
        E_UNCLOSED = 3'd3, E_ESCAPE = 3'd4;

    localparam logic [7:0] CH_UNDER = 8'h5F, CH_CR = 8'h0D, CH_LF = 8'h0A,
        CH_TAB = 8'h09, CH_DOT = 8'h2E, CH_BSLASH = 8'h5C, CH_SPACE = 8'h20,
        CH_QUOTE = 8'h27, CH_DQUOTE = 8'h22, CH_SLASH = 8'h2F, CH_STAR = 8'h2A,
        CH_EQ = 8'h3D, CH_LT = 8'h3C, CH_GT = 8'h3E, CH_AMP = 8'h26, CH_PLUS = 8'h2B,
        CH_MINUS = 8'h2D, CH_BAR = 8'h7C, CH_COLON = 8'h3A;

    typedef enum logic [12:0] {
        M_IDLE       = 13'b0000000000001,
        M_AFTER_CR   = 13'b0000000000010,
        M_IDENT      = 13'b0000000000100,
        M_NUMBER     = 13'b0000000001000,
        M_DOT        = 13'b0000000010000,
        M_OP         = 13'b0000000100000,
        M_SHIFT      = 13'b0000001000000,
        M_LINE       = 13'b0000010000000,
        M_BLOCK      = 13'b0000100000000,
        M_BLOCK_CR   = 13'b0001000000000,
        M_CHAR_OPEN  = 13'b0010000000000,
        M_CHAR_CLOSE = 13'b0100000000000,
        M_STRING     = 13'b1000000000000
    } mode_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == CH_UNDER;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // escape value; bit 8 set when the escape is not valid
    function automatic logic [8:0] decode_escape(input logic [7:0] c);
        case (c)
            "b":       return 9'd8;
            "t":       return 9'd9;
            "n":       return 9'd10;
            "f":       return 9'd12;
            "r":       return 9'd13;
            CH_QUOTE:  return 9'd39;
            CH_DQUOTE: return 9'd34;
            CH_BSLASH: return 9'd92;
            default:   return 9'h100;
        endcase
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] c);
        case (c)
            ",":     return K_COMMA;
            ";":     return K_SEMI;
            "(":     return K_LPAREN;
            ")":     return K_RPAREN;
            "[":     return K_LBRACKET;
            "]":     return K_RBRACKET;
            "{":     return K_LBRACE;
            "}":     return K_RBRACE;
            "?":     return K_QUES;
            "~":     return K_TILDE;
            default: return K_NONE;
        endcase
    endfunction

    function automatic logic [5:0] lead_kind(input logic [7:0] c);
        case (c)
            CH_AMP:   return K_AMP;
            CH_STAR:  return K_STAR;
            CH_PLUS:  return K_PLUS;
            CH_MINUS: return K_SUB;
            "!":      return K_BANG;
            CH_SLASH: return K_SLASH;
            "%":      return K_PERCENT;
            CH_LT:    return K_LT;
            CH_GT:    return K_GT;
            "^":      return K_CARET;
            CH_BAR:   return K_BAR;
            CH_COLON: return K_COLON;
            CH_EQ:    return K_EQ;
            default:  return K_NONE;
        endcase
    endfunction

    function automatic logic [5:0] pair_kind(input logic [5:0] lead, input logic [7:0] c);
        if (c == CH_EQ) begin
            case (lead)
                K_AMP:     return K_AMPEQ;
                K_STAR:    return K_STAREQ;
                K_PLUS:    return K_PLUSEQ;
                K_SUB:     return K_SUBEQ;
                K_BANG:    return K_BANGEQ;
                K_SLASH:   return K_SLASHEQ;
                K_PERCENT: return K_PERCENTEQ;
                K_LT:      return K_LTEQ;
                K_GT:      return K_GTEQ;
                K_CARET:   return K_CARETEQ;
                K_BAR:     return K_BAREQ;
                K_EQ:      return K_EQEQ;
                default:   return K_NONE;
            endcase
        end
        if (lead == K_AMP && c == CH_AMP) return K_AMPAMP;
        if (lead == K_PLUS && c == CH_PLUS) return K_PLUSPLUS;
        if (lead == K_SUB && c == CH_MINUS) return K_SUBSUB;
        if (lead == K_SUB && c == CH_GT) return K_ARROW;
        if (lead == K_BAR && c == CH_BAR) return K_BARBAR;
        if (lead == K_COLON && c == CH_COLON) return K_COLONCOLON;
        return K_NONE;
    endfunction

endpackage

FILE: rtl/core/c_token_scanner.sv
// Top level of the streaming C token scanner.
//  channel | dir | handshake           | payload
//  s_      | in  | s_valid / s_ready   | s_item  (src_byte, end_of_file)
//  m_      | out | m_valid / m_ready   | m_item  (token fields)
// One byte is taken per cycle while s_ready is high; the scanner state updates in a single step.
// A byte's tokens (up to two) pass the front holding register and then a two-entry
// queue before they leave on m_.
// A byte that closes a held token and emits its own, or an end-of-file item with a held
// token that is not a character or string literal, gives two results, sent one after the other.
// Reset (aresetn low, synchronous) empties the queue and restores the scan state.
// Output stalls back up to s_ready only when the queue is full and the front holding register is occupied.
module c_token_scanner #(
    parameter int OFFSET_BITS = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  cts_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output cts_pkg::out_item_t m_item
);
    import cts_pkg::*;

    logic      tok_valid, tok_ready;
    tok_pair_t tok_pair;

    cts_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
        .aclk, .aresetn,
        .in_valid(s_valid), .in_ready(s_ready), .in_item(s_item),
        .tok_valid, .tok_ready, .tok_pair
    );

    cts_back u_back (
        .aclk, .aresetn,
        .tok_valid, .tok_ready, .tok_pair,
        .out_valid(m_valid), .out_ready(m_ready), .out_item(m_item)
    );
endmodule

FILE: rtl/core/cts_front.sv
// Front end: per-byte scanner state machine producing up to two tokens per byte.
module cts_front #(
    parameter int OFFSET_BITS = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  cts_pkg::in_item_t  in_item,
    output logic               tok_valid,
    input  logic               tok_ready,
    output cts_pkg::tok_pair_t tok_pair
);
    import cts_pkg::*;

    localparam int OB = OFFSET_BITS;

    mode_t         mode_reg, mode_next;
    logic [OB-1:0] off_reg, off_next;
    logic [23:0]   line_reg, line_next;
    logic [OB-1:0] lbeg_reg, lbeg_next;
    logic [OB-1:0] tbeg_reg, tbeg_next;
    logic [OB-1:0] tlast_reg, tlast_next;
    logic [5:0]    pend_reg, pend_next;
    logic [7:0]    lit_reg, lit_next;
    logic          esc_reg, esc_next;
    logic          star_reg, star_next;
    logic          halt_reg, halt_next;

    logic          valid_reg;
    tok_pair_t     pair_reg, pair_next;

    logic          take;
    logic [7:0]    c;
    logic [OB-1:0] off;
    logic [OB-1:0] off1;
    logic [8:0]    escv;
    logic [5:0]    k;
    logic          start;

    assign in_ready  = !valid_reg || tok_ready;
    assign take      = in_valid && in_ready;
    assign tok_valid = valid_reg;
    assign tok_pair  = pair_reg;
    assign c         = in_item.src_byte;
    assign off       = off_reg;
    assign off1      = off_reg + {{(OB-1){1'b0}}, 1'b1};
    assign escv      = decode_escape(c);

    function automatic logic [23:0] lo24(input logic [OB-1:0] v);
        logic [OB+23:0] w;
        w = {24'd0, v};
        return w[23:0];
    endfunction

    always_comb begin
        out_item_t t;
        logic [23:0] line_t;
        logic [OB-1:0] lbeg_t;
        mode_next  = mode_reg;
        off_next   = off_reg;
        line_next  = line_reg;
        lbeg_next  = lbeg_reg;
        tbeg_next  = tbeg_reg;
        tlast_next = tlast_reg;
        pend_next  = pend_reg;
        lit_next   = lit_reg;
        esc_next   = esc_reg;
        star_next  = star_reg;
        halt_next  = halt_reg;
        pair_next  = '0;
        start      = 1'b0;
        k          = K_NONE;
        t          = '0;
        line_t     = '0;
        lbeg_t     = '0;

        // token emission uses line info as it stands when emitted
        if (in_item.end_of_file) begin
            if (!halt_reg) begin
                t.line_number       = line_reg;
                t.line_start_offset = lo24(lbeg_reg);
                t.start_offset      = lo24(tbeg_reg);
                t.end_offset        = lo24(tlast_reg);
                pair_next.count     = 2'd1;
                case (mode_reg)
                    M_IDENT:  t.token_kind = K_IDENT;
                    M_NUMBER, M_SHIFT: t.token_kind = pend_reg;
                    M_DOT: begin
                        t.token_kind = K_DOT;
                        t.end_offset = lo24(tbeg_reg);
                    end
                    M_OP: begin
                        t.token_kind = pend_reg;
                        t.end_offset = lo24(tbeg_reg);
                    end
                    M_CHAR_OPEN, M_CHAR_CLOSE, M_STRING: begin
                        t.token_kind  = (mode_reg == M_STRING) ? K_STRING : K_CHAR;
                        t.end_offset  = lo24(off);
                        t.error_code  = (esc_reg && mode_reg != M_CHAR_CLOSE) ?
                                        E_ESCAPE : E_UNCLOSED;
                        t.final_token = 1'b1;
                        pair_next.count = 2'd0;
                    end
                    default: pair_next.count = 2'd0;
                endcase
                pair_next.tok0 = t;
                if (!t.final_token) begin
                    t = '0;
                    t.token_kind        = K_EOF;
                    t.start_offset      = lo24(off);
                    t.end_offset        = lo24(off);
                    t.line_number       = line_reg;
                    t.line_start_offset = lo24(lbeg_reg);
                    t.final_token       = 1'b1;
                    if (pair_next.count == 2'd0) pair_next.tok0 = t;
                    else pair_next.tok1 = t;
                end
                pair_next.count = pair_next.count + 2'd1;
            end
            mode_next = M_IDLE; off_next = '0; line_next = 24'd1; lbeg_next = '0;
            tbeg_next = '0; tlast_next = '0; pend_next = '0; lit_next = '0;
            esc_next = 1'b0; star_next = 1'b0; halt_next = 1'b0;
        end else if (!halt_reg) begin
            off_next = off1;
            t.line_number       = line_reg;
            t.line_start_offset = lo24(lbeg_reg);
            t.start_offset      = lo24(tbeg_reg);
            case (mode_reg)
                M_AFTER_CR: begin
                    mode_next = M_IDLE;
                    if (c == CH_LF) lbeg_next = off1;
                    else start = 1'b1;
                end
                M_IDENT: begin
                    if (is_alpha(c) || is_digit(c)) tlast_next = off;
                    else begin
                        t.token_kind = K_IDENT; t.end_offset = lo24(tlast_reg);
                        pair_next.count = 2'd1; start = 1'b1;
                    end
                end
                M_NUMBER: begin
                    if (is_alpha(c) || is_digit(c) || c == CH_DOT) begin
                        if (c == CH_DOT) pend_next = K_FLOAT;
                        tlast_next = off;
                    end else begin
                        t.token_kind = pend_reg; t.end_offset = lo24(tlast_reg);
                        pair_next.count = 2'd1; start = 1'b1;
                    end
                end
                M_DOT: begin
                    if (is_digit(c)) begin
                        mode_next = M_NUMBER; pend_next = K_FLOAT; tlast_next = off;
                    end else begin
                        t.token_kind = K_DOT; t.end_offset = lo24(tbeg_reg);
                        pair_next.count = 2'd1; start = 1'b1;
                    end
                end
                M_OP: begin
                    k = pair_kind(pend_reg, c);
                    if (pend_reg == K_SLASH && c == CH_SLASH) mode_next = M_LINE;
                    else if (pend_reg == K_SLASH && c == CH_STAR) begin
                        mode_next = M_BLOCK; star_next = 1'b0;
                    end else if ((pend_reg == K_LT && c == CH_LT) ||
                                 (pend_reg == K_GT && c == CH_GT)) begin
                        mode_next = M_SHIFT;
                        pend_next = (pend_reg == K_LT) ? K_LTLT : K_GTGT;
                        tlast_next = off;
                    end else if (k != K_NONE) begin
                        t.token_kind = k; t.end_offset = lo24(off);
                        pair_next.count = 2'd1; mode_next = M_IDLE;
                    end else begin
                        t.token_kind = pend_reg; t.end_offset = lo24(tbeg_reg);
                        pair_next.count = 2'd1; start = 1'b1;
                    end
                end
                M_SHIFT: begin
                    if (c == CH_EQ) begin
                        t.token_kind = pend_reg - 6'd1; t.end_offset = lo24(off);
                        pair_next.count = 2'd1; mode_next = M_IDLE;
                    end else begin
                        t.token_kind = pend_reg; t.end_offset = lo24(tlast_reg);
                        pair_next.count = 2'd1; start = 1'b1;
                    end
                end
                M_LINE: begin
                    if (c == CH_CR || c == CH_LF) start = 1'b1;
                end
                M_BLOCK, M_BLOCK_CR: begin
                    mode_next = M_BLOCK;
                    if (mode_reg == M_BLOCK_CR && c == CH_LF) lbeg_next = off1;
                    else if (c == CH_CR || c == CH_LF) begin
                        if (line_reg != 24'hFFFFFF) line_next = line_reg + 24'd1;
                        lbeg_next = off1; star_next = 1'b0;
                        if (c == CH_CR) mode_next = M_BLOCK_CR;
                    end else if (c == CH_SLASH && star_reg) mode_next = M_IDLE;
                    else star_next = (c == CH_STAR);
                end
                M_CHAR_OPEN: begin
                    t.token_kind = K_CHAR; t.end_offset = lo24(off);
                    t.final_token = 1'b1;
                    if (esc_reg) begin
                        if (escv[8]) begin
                            t.error_code = E_ESCAPE; pair_next.count = 2'd1;
                        end else begin
                            lit_next = escv[7:0]; esc_next = 1'b0;
                            mode_next = M_CHAR_CLOSE;
                        end
                    end else if (c == CH_QUOTE) begin
                        t.error_code = E_EMPTY; pair_next.count = 2'd1;
                    end else if (c == CH_LF || c == CH_CR) begin
                        t.error_code = E_UNCLOSED; pair_next.count = 2'd1;
                    end else if (c == CH_BSLASH) esc_next = 1'b1;
                    else begin
                        lit_next = c; mode_next = M_CHAR_CLOSE;
                    end
                end
                M_CHAR_CLOSE: begin
                    t.token_kind = K_CHAR; t.end_offset = lo24(off);
                    pair_next.count = 2'd1; mode_next = M_IDLE;
                    if (c == CH_QUOTE) t.char_value = lit_reg;
                    else begin
                        t.error_code = E_UNCLOSED; t.final_token = 1'b1;
                    end
                end
                M_STRING: begin
                    t.token_kind = K_STRING; t.end_offset = lo24(off);
                    t.final_token = 1'b1;
                    if (esc_reg) begin
                        if (escv[8]) begin
                            t.error_code = E_ESCAPE; pair_next.count = 2'd1;
                        end else esc_next = 1'b0;
                    end else if (c == CH_DQUOTE) begin
                        t.final_token = 1'b0; pair_next.count = 2'd1;
                        mode_next = M_IDLE;
                    end else if (c == CH_LF || c == CH_CR) begin
                        t.error_code = E_UNCLOSED; pair_next.count = 2'd1;
                    end else if (c == CH_BSLASH) esc_next = 1'b1;
                end
                default: start = 1'b1;
            endcase
            pair_next.tok0 = t;
            if (t.final_token && pair_next.count != 2'd0) begin
                halt_next = 1'b1; mode_next = M_IDLE;
            end

            // start of a new token on this byte
            if (start) begin
                line_t = line_reg;
                lbeg_t = lbeg_reg;
                mode_next = M_IDLE;
                t = '0;
                if (c == CH_CR || c == CH_LF) begin
                    if (line_reg != 24'hFFFFFF) line_next = line_reg + 24'd1;
                    lbeg_next = off1;
                    if (c == CH_CR) mode_next = M_AFTER_CR;
                end else if (c != CH_SPACE && c != CH_TAB) begin
                    tbeg_next = off; tlast_next = off;
                    t.line_number = line_t; t.line_start_offset = lo24(lbeg_t);
                    t.start_offset = lo24(off); t.end_offset = lo24(off);
                    if (is_alpha(c)) mode_next = M_IDENT;
                    else if (is_digit(c)) begin
                        mode_next = M_NUMBER; pend_next = K_INT;
                    end else if (c == CH_DOT) mode_next = M_DOT;
                    else if (c == CH_QUOTE) begin
                        mode_next = M_CHAR_OPEN; esc_next = 1'b0;
                    end else if (c == CH_DQUOTE) begin
                        mode_next = M_STRING; esc_next = 1'b0;
                    end else if (single_kind(c) != K_NONE) begin
                        t.token_kind = single_kind(c);
                        pair_next.tok1 = t; pair_next.count = pair_next.count + 2'd1;
                    end else if (lead_kind(c) != K_NONE) begin
                        mode_next = M_OP; pend_next = lead_kind(c);
                    end else begin
                        t.token_kind = K_DOT; t.error_code = E_UNKNOWN;
                        t.final_token = 1'b1; halt_next = 1'b1;
                        pair_next.tok1 = t; pair_next.count = pair_next.count + 2'd1;
                    end
                    // shift the new token down when no earlier token was emitted
                    if (pair_next.count == 2'd1 && (single_kind(c) != K_NONE ||
                        (!is_alpha(c) && !is_digit(c) && c != CH_DOT && c != CH_QUOTE &&
                         c != CH_DQUOTE && lead_kind(c) == K_NONE)))
                        pair_next.tok0 = t;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            mode_reg  <= M_IDLE;
            off_reg   <= '0;
            line_reg  <= 24'd1;
            lbeg_reg  <= '0;
            tbeg_reg  <= '0;
            tlast_reg <= '0;
            pend_reg  <= '0;
            lit_reg   <= '0;
            esc_reg   <= 1'b0;
            star_reg  <= 1'b0;
            halt_reg  <= 1'b0;
        end else begin
            if (take) begin
                valid_reg <= (pair_next.count != 2'd0);
                pair_reg  <= pair_next;
                mode_reg  <= mode_next;
                off_reg   <= off_next;
                line_reg  <= line_next;
                lbeg_reg  <= lbeg_next;
                tbeg_reg  <= tbeg_next;
                tlast_reg <= tlast_next;
                pend_reg  <= pend_next;
                lit_reg   <= lit_next;
                esc_reg   <= esc_next;
                star_reg  <= star_next;
                halt_reg  <= halt_next;
            end else if (tok_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (pair_reg.count == 2'd1 || pair_reg.count == 2'd2))
        else $error("front: bad token count");
    a_line: assert property (@(posedge aclk) disable iff (!aresetn)
        line_reg != 24'd0) else $error("front: line count zero");
    a_halt: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_reg |-> mode_reg == M_IDLE) else $error("front: halted while in a token");
endmodule

FILE: rtl/core/cts_back.sv
// Back end: small queue of token pairs and the serializer onto the result channel.
module cts_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                tok_valid,
    output logic                tok_ready,
    input  cts_pkg::tok_pair_t  tok_pair,
    output logic                out_valid,
    input  logic                out_ready,
    output cts_pkg::out_item_t  out_item
);
    import cts_pkg::*;

    tok_pair_t  q_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       sel_reg;
    logic       push, pop;
    tok_pair_t  head;

    assign head      = q_reg[rp_reg];
    assign tok_ready = (cnt_reg != 2'd2);
    assign push      = tok_valid && tok_ready;
    assign out_valid = (cnt_reg != 2'd0);
    assign out_item  = sel_reg ? head.tok1 : head.tok0;
    assign pop       = out_valid && out_ready && (sel_reg || head.count == 2'd1);

    always_ff @(posedge aclk) begin
        if (push) q_reg[wp_reg] <= tok_pair;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
            sel_reg <= 1'b0;
        end else begin
            if (push) wp_reg <= !wp_reg;
            if (pop) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
            if (pop) sel_reg <= 1'b0;
            else if (out_valid && out_ready) sel_reg <= 1'b1;
        end
    end

    a_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'd2) else $error("back: queue overflow");
    a_sel: assert property (@(posedge aclk) disable iff (!aresetn)
        sel_reg |-> (out_valid && head.count == 2'd2)) else $error("back: bad select");
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd0 |-> !sel_reg) else $error("back: select set on empty queue");
endmodule
